[design/line_tile_binning_unit_macros.svh]
// Assertion helpers shared by the design files
`ifndef LINE_TILE_BINNING_UNIT_MACROS_SVH
`define LINE_TILE_BINNING_UNIT_MACROS_SVH
// implication checked every cycle outside reset
`define LTB_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define LTB_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[design/ltb_pkg.sv]
// ----------------------------------------------------------------------
// ltb_pkg
// Shared types and constants of the line tile binning unit.
// ----------------------------------------------------------------------
package ltb_pkg;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;
	localparam int CFG_BITS = 7;
	localparam int SLOT_BITS = 6;
	localparam int NUM_TILES = 64;
	localparam int QUEUE_DEPTH = 2;
endpackage

[design/ltb_front.sv]
// ----------------------------------------------------------------------
// ltb_front
// Accepts items, writes tile loads into the box table, queues line tests.
// ----------------------------------------------------------------------
module ltb_front #(
	parameter int COORD_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic [ltb_pkg::SLOT_BITS-1:0] slot,
	input  logic signed [COORD_BITS-1:0] bx0,
	input  logic signed [COORD_BITS-1:0] by0,
	input  logic signed [COORD_BITS-1:0] bx1,
	input  logic signed [COORD_BITS-1:0] by1,
	input  logic signed [COORD_BITS-1:0] sx,
	input  logic signed [COORD_BITS-1:0] sy,
	input  logic signed [COORD_BITS-1:0] ex,
	input  logic signed [COORD_BITS-1:0] ey,
	input  logic [COORD_BITS-2:0] thick,
	input  logic back_busy,
	output logic wr_en,
	output logic [ltb_pkg::SLOT_BITS-1:0] wr_slot,
	output logic [4*COORD_BITS-1:0] wr_box,
	output logic q_valid,
	input  logic q_pop,
	output logic [5*COORD_BITS-2:0] q_line
);
	localparam int D = ltb_pkg::QUEUE_DEPTH;
	localparam int LW = 5 * COORD_BITS - 1;
	logic [LW-1:0] mem_q [D];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic acc, push;

	// a load waits until queued and running tests are done with the table
	assign in_stall = (op == ltb_pkg::OP_TEST) ? (cnt_q == 2'(D)) : (q_valid || back_busy);
	assign acc = in_valid && !in_stall;
	assign push = acc && (op == ltb_pkg::OP_TEST);
	assign wr_en = acc && (op == ltb_pkg::OP_LOAD) && (32'(slot) < ltb_pkg::NUM_TILES);
	assign wr_slot = slot;
	assign wr_box = {by1, bx1, by0, bx0};
	assign q_valid = cnt_q != 2'd0;
	assign q_line = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {thick, ey, ex, sy, sx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	`include "line_tile_binning_unit_macros.svh"
	`LTB_ASSERT_IMP(a_no_overflow, push, cnt_q != 2'(D) || q_pop)
	`LTB_ASSERT_IMP(a_no_underflow, q_pop, q_valid)
	`LTB_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 2'(D))
endmodule

[design/ltb_back.sv]
// ----------------------------------------------------------------------
// ltb_back
// Holds the box table and walks it box by box for one queued line at a time.
// ----------------------------------------------------------------------
module ltb_back #(
	parameter int COORD_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [ltb_pkg::CFG_BITS-1:0] tiles_in_use,
	input  logic wr_en,
	input  logic [ltb_pkg::SLOT_BITS-1:0] wr_slot,
	input  logic [4*COORD_BITS-1:0] wr_box,
	input  logic q_valid,
	output logic q_pop,
	input  logic [5*COORD_BITS-2:0] q_line,
	output logic busy,
	output logic out_valid,
	input  logic out_stall,
	output logic [ltb_pkg::SLOT_BITS-1:0] hit_tile,
	output logic found,
	output logic last
);
	localparam int CW = COORD_BITS + 2;
	localparam logic [1:0] ST_IDLE = 2'd0, ST_READ = 2'd1, ST_TEST = 2'd2, ST_DONE = 2'd3;
	localparam logic [6:0] MAXT = 7'(ltb_pkg::NUM_TILES);

	logic [4*COORD_BITS-1:0] tab_q [ltb_pkg::NUM_TILES];
	logic [4*COORD_BITS-1:0] rd_q;
	logic [1:0] st_q;
	logic [6:0] idx_q, n_q, tidx_q;
	logic [5*COORD_BITS-2:0] line_q;
	logic ov_q, ofound_q, olast_q;
	logic [ltb_pkg::SLOT_BITS-1:0] otile_q;
	logic out_free, hit, last_tile, emit;

	// the box read is held while the test state waits on the output
	always_ff @(posedge clk) begin
		if (wr_en) tab_q[wr_slot] <= wr_box;
		if (st_q == ST_READ) rd_q <= tab_q[idx_q[ltb_pkg::SLOT_BITS-1:0]];
	end

	function automatic logic axis_ok(input logic signed [CW-1:0] lo, hi, s, e);
		logic signed [CW-1:0] d, a, b, mn, mx;
		d = e - s; a = lo - s; b = hi - s;
		mn = (a < b) ? a : b;
		mx = (a < b) ? b : a;
		if (d > 0) return (mn < d) && (mx > 0);
		else if (d < 0) return (mx > d) && (mn < 0);
		else return (mn <= 0) && (mx >= 0);
	endfunction

	logic signed [CW-1:0] hw, x0, y0, x1, y1, lsx, lsy, lex, ley;
	always_comb begin
		hw = CW'(signed'({1'b0, line_q[5*COORD_BITS-2:4*COORD_BITS]} >> 1));
		x0 = CW'(signed'(rd_q[COORD_BITS-1:0])) - hw;
		y0 = CW'(signed'(rd_q[2*COORD_BITS-1:COORD_BITS])) - hw;
		x1 = CW'(signed'(rd_q[3*COORD_BITS-1:2*COORD_BITS])) + hw;
		y1 = CW'(signed'(rd_q[4*COORD_BITS-1:3*COORD_BITS])) + hw;
		lsx = CW'(signed'(line_q[COORD_BITS-1:0]));
		lsy = CW'(signed'(line_q[2*COORD_BITS-1:COORD_BITS]));
		lex = CW'(signed'(line_q[3*COORD_BITS-1:2*COORD_BITS]));
		ley = CW'(signed'(line_q[4*COORD_BITS-1:3*COORD_BITS]));
		hit = axis_ok(x0, x1, lsx, lex) && axis_ok(y0, y1, lsy, ley);
	end

	// a hit is held back one tile so the last flag can go on the final hit
	logic pend_q;
	logic [ltb_pkg::SLOT_BITS-1:0] ptile_q;

	assign out_free = !ov_q || !out_stall;
	assign last_tile = (tidx_q + 7'd1) == n_q;
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign busy = (st_q == ST_READ) || (st_q == ST_TEST);
	assign emit = ((st_q == ST_TEST) && hit && pend_q && out_free) ||
		((st_q == ST_DONE) && out_free);
	assign out_valid = ov_q;
	assign hit_tile = otile_q;
	assign found = ofound_q;
	assign last = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
			pend_q <= 1'b0;
			line_q <= '0;
			idx_q <= '0; n_q <= '0; tidx_q <= '0;
			ofound_q <= 1'b0; olast_q <= 1'b0; otile_q <= '0; ptile_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						line_q <= q_line;
						n_q <= (tiles_in_use > MAXT) ? MAXT : tiles_in_use;
						idx_q <= '0;
						pend_q <= 1'b0;
						st_q <= (tiles_in_use == '0) ? ST_DONE : ST_READ;
					end
				end
				ST_READ: begin
					tidx_q <= idx_q;
					idx_q <= idx_q + 7'd1;
					st_q <= ST_TEST;
				end
				ST_TEST: begin
					if (!hit || !pend_q || out_free) begin
						if (hit && pend_q) begin
							otile_q <= ptile_q;
							ofound_q <= 1'b1; olast_q <= 1'b0;
						end
						if (hit) begin
							pend_q <= 1'b1;
							ptile_q <= tidx_q[ltb_pkg::SLOT_BITS-1:0];
						end
						st_q <= last_tile ? ST_DONE : ST_READ;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						olast_q <= 1'b1;
						ofound_q <= pend_q;
						otile_q <= pend_q ? ptile_q : '0;
						pend_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`include "line_tile_binning_unit_macros.svh"
	`LTB_ASSERT_IMP(a_hold, ov_q && out_stall, 1'b1)
	`LTB_ASSERT_NXT(a_stall_keep, ov_q && out_stall, ov_q && $stable(otile_q))
	`LTB_ASSERT_IMP(a_nofound_zero, ov_q && !ofound_q, olast_q && otile_q == '0)
	`LTB_ASSERT_IMP(a_n_range, 1'b1, n_q <= MAXT)
endmodule

[design/line_tile_binning_unit.sv]
// ----------------------------------------------------------------------
// line_tile_binning_unit
// Thick line segment against tile box binning with a slab test per axis.
// ----------------------------------------------------------------------
// Load item: written to the box table at acceptance; a load is stalled
// while any test is queued or its boxes are still being read and tested.
// Test item: each box in use is read, then tested; output stalls hold it.
// A two-entry queue lets new tests enter while a test runs.
// Reset clears control state and tiles_in_use; the box table is not cleared.
module line_tile_binning_unit #(
	parameter int COORD_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ltb_pkg::CFG_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	input  logic [ltb_pkg::SLOT_BITS-1:0] tile_slot,
	input  logic signed [COORD_BITS-1:0] box_x_min,
	input  logic signed [COORD_BITS-1:0] box_y_min,
	input  logic signed [COORD_BITS-1:0] box_x_max,
	input  logic signed [COORD_BITS-1:0] box_y_max,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COORD_BITS-2:0] thickness,
	output logic out_valid,
	input  logic out_stall,
	output logic [ltb_pkg::SLOT_BITS-1:0] hit_tile,
	output logic found,
	output logic last
);
	logic [ltb_pkg::CFG_BITS-1:0] tiles_q;
	logic wr_en, q_valid, q_pop, back_busy;
	logic [ltb_pkg::SLOT_BITS-1:0] wr_slot;
	logic [4*COORD_BITS-1:0] wr_box;
	logic [5*COORD_BITS-2:0] q_line;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tiles_q <= '0;
		else if (cfg_valid) tiles_q <= cfg_data;
	end

	ltb_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .op(operation), .slot(tile_slot),
		.bx0(box_x_min), .by0(box_y_min), .bx1(box_x_max), .by1(box_y_max),
		.sx(start_x), .sy(start_y), .ex(end_x), .ey(end_y), .thick(thickness),
		.back_busy, .wr_en, .wr_slot, .wr_box, .q_valid, .q_pop, .q_line
	);

	ltb_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .tiles_in_use(tiles_q), .wr_en, .wr_slot, .wr_box,
		.q_valid, .q_pop, .q_line, .busy(back_busy),
		.out_valid, .out_stall, .hit_tile, .found, .last
	);
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------
// tb_top
// Self-checking bench for the line tile binning unit: loads tile boxes,
// sends thick segments under random valid/stall traffic and checks every
// hit result against a slab-test predictor running on the bench side.
// ----------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NT = 64;
	localparam int CB = 20;
	localparam int ONE = 65536;
	localparam int SETTLE = 2 * NT + 40;

	typedef struct {
		logic op;
		logic [5:0] slot;
		logic signed [CB-1:0] bx0, by0, bx1, by1;
		logic signed [CB-1:0] sx, sy, ex, ey;
		logic [CB-2:0] thick;
	} line_item_t;

	typedef struct {
		logic [5:0] tile;
		logic hit;
		logic fin;
	} bin_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ltb_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = 1'b0;
	logic [5:0] tile_slot = '0;
	logic signed [CB-1:0] box_x_min = '0, box_y_min = '0, box_x_max = '0, box_y_max = '0;
	logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [CB-2:0] thickness = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] hit_tile;
	logic found;
	logic last;

	line_item_t pending_items[$];
	bin_result_t bin_expect[$];
	line_item_t cur_item;
	logic signed [CB-1:0] tbl_x0[NT], tbl_y0[NT], tbl_x1[NT], tbl_y1[NT];
	logic [6:0] tiles_cfg = '0;
	int n_mismatch = 0;
	int n_loads = 0, n_lines = 0, n_hits = 0, n_results = 0;
	int burst_left = 4, gap_left = 0;
	int stall_pct = 0, stall_phase_cnt = 0, hold_cnt = 0;
	bit long_hold_done = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	line_tile_binning_unit #(.COORD_BITS(CB)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .tile_slot(tile_slot),
		.box_x_min(box_x_min), .box_y_min(box_y_min),
		.box_x_max(box_x_max), .box_y_max(box_y_max),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.thickness(thickness),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit_tile(hit_tile), .found(found), .last(last)
	);

	function automatic bit slab_ok(longint lo, longint hi, longint s, longint e);
		longint d, a, b, mn, mx;
		d = e - s;
		a = lo - s;
		b = hi - s;
		mn = (a < b) ? a : b;
		mx = (a > b) ? a : b;
		if (d > 0)
			return mn < d && mx > 0;
		if (d < 0)
			return mx > d && mn < 0;
		return mn <= 0 && mx >= 0;
	endfunction

	// apply one accepted item to the bench copy of the table, queue its expected results
	task automatic bin_line(input line_item_t it);
		longint hw;
		int n, cnt;
		bin_result_t r;
		if (it.op == ltb_pkg::OP_LOAD) begin
			tbl_x0[it.slot] = it.bx0;
			tbl_y0[it.slot] = it.by0;
			tbl_x1[it.slot] = it.bx1;
			tbl_y1[it.slot] = it.by1;
			n_loads++;
		end else begin
			hw = longint'(it.thick >> 1);
			n = (tiles_cfg > NT) ? NT : int'(tiles_cfg);
			cnt = 0;
			for (int t = 0; t < n; t++) begin
				if (slab_ok(longint'(tbl_x0[t]) - hw, longint'(tbl_x1[t]) + hw,
						longint'(it.sx), longint'(it.ex)) &&
						slab_ok(longint'(tbl_y0[t]) - hw, longint'(tbl_y1[t]) + hw,
						longint'(it.sy), longint'(it.ey))) begin
					r.tile = t[5:0];
					r.hit = 1'b1;
					r.fin = 1'b0;
					bin_expect.push_back(r);
					cnt++;
				end
			end
			if (cnt == 0) begin
				r.tile = '0;
				r.hit = 1'b0;
				r.fin = 1'b1;
				bin_expect.push_back(r);
			end else begin
				bin_expect[bin_expect.size() - 1].fin = 1'b1;
				n_hits += cnt;
			end
			n_lines++;
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("[%0t] result error: %s", $realtime, what);
		n_mismatch++;
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				bin_line(cur_item);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					in_valid <= 1'b1;
					operation <= cur_item.op;
					tile_slot <= cur_item.slot;
					box_x_min <= cur_item.bx0;
					box_y_min <= cur_item.by0;
					box_x_max <= cur_item.bx1;
					box_y_max <= cur_item.by1;
					start_x <= cur_item.sx;
					start_y <= cur_item.sy;
					end_x <= cur_item.ex;
					end_y <= cur_item.ey;
					thickness <= cur_item.thick;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks results, stalls on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (bin_expect.size() == 0) begin
					flag_mismatch($sformatf("unexpected result tile %0d found %0b last %0b",
						hit_tile, found, last));
				end else begin
					bin_result_t r;
					r = bin_expect.pop_front();
					if (hit_tile !== r.tile)
						flag_mismatch($sformatf("hit_tile %0d, want %0d", hit_tile, r.tile));
					if (found !== r.hit)
						flag_mismatch($sformatf("found %0b, want %0b", found, r.hit));
					if (last !== r.fin)
						flag_mismatch($sformatf("last %0b, want %0b", last, r.fin));
				end
			end
			// one long hold-off while the sender still has plenty of items queued
			if (!long_hold_done && tiles_cfg != '0 && pending_items.size() > 60) begin
				long_hold_done = 1'b1;
				hold_cnt = 600;
			end
			if (++stall_phase_cnt >= 250) begin
				stall_phase_cnt = 0;
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 85;
				endcase
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	function automatic logic signed [CB-1:0] rnd_coord(int span);
		return CB'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic line_item_t noise_item();
		line_item_t it;
		it.op = 1'($urandom_range(0, 1));
		it.slot = 6'($urandom);
		it.bx0 = CB'($urandom);
		it.by0 = CB'($urandom);
		it.bx1 = CB'($urandom);
		it.by1 = CB'($urandom);
		it.sx = CB'($urandom);
		it.sy = CB'($urandom);
		it.ex = CB'($urandom);
		it.ey = CB'($urandom);
		it.thick = (CB-1)'($urandom);
		return it;
	endfunction

	function automatic line_item_t box_item(int slot, int x0, int y0, int x1, int y1);
		line_item_t it;
		it = noise_item();
		it.op = ltb_pkg::OP_LOAD;
		it.slot = slot[5:0];
		it.bx0 = x0[CB-1:0];
		it.by0 = y0[CB-1:0];
		it.bx1 = x1[CB-1:0];
		it.by1 = y1[CB-1:0];
		return it;
	endfunction

	function automatic line_item_t seg_item(int sx, int sy, int ex, int ey, int th);
		line_item_t it;
		it = noise_item();
		it.op = ltb_pkg::OP_TEST;
		it.sx = sx[CB-1:0];
		it.sy = sy[CB-1:0];
		it.ex = ex[CB-1:0];
		it.ey = ey[CB-1:0];
		it.thick = th[CB-2:0];
		return it;
	endfunction

	function automatic line_item_t rand_item();
		line_item_t it;
		int cx, cy, hx, hy, sx, sy, dx, dy, th;
		if ($urandom_range(0, 99) < 12)
			return noise_item();
		if ($urandom_range(0, 99) < 30) begin
			cx = rnd_coord(5 * ONE);
			cy = rnd_coord(5 * ONE);
			hx = $urandom_range(0, 3 * ONE / 2);
			hy = $urandom_range(0, 3 * ONE / 2);
			if ($urandom_range(0, 9) == 0)
				hx = -hx;
			return box_item($urandom_range(0, 63), cx - hx, cy - hy, cx + hx, cy + hy);
		end
		sx = rnd_coord(5 * ONE);
		sy = rnd_coord(5 * ONE);
		dx = rnd_coord(3 * ONE);
		dy = rnd_coord(3 * ONE);
		case ($urandom_range(0, 9))
			0: dx = 0;
			1: dy = 0;
			2: begin dx = 0; dy = 0; end
			default: ;
		endcase
		th = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 524287) : $urandom_range(0, ONE);
		return seg_item(sx, sy, sx + dx, sy + dy, th);
	endfunction

	task automatic write_tiles(input int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[6:0];
		do @(posedge clk); while (!cfg_ready);
		tiles_cfg = v[6:0];
		cfg_valid <= 1'b0;
	endtask

	// sender pauses until every expected result is back
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || bin_expect.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic rand_phase(input int cfg, input int count);
		write_tiles(cfg);
		for (int i = 0; i < count; i++)
			pending_items.push_back(rand_item());
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill the whole table on an 8x8 grid before any tile is tested
		write_tiles(0);
		for (int i = 0; i < NT; i++)
			pending_items.push_back(box_item(i, (i % 8 - 4) * ONE, (i / 8 - 4) * ONE,
				(i % 8 - 3) * ONE - 1, (i / 8 - 3) * ONE - 1));
		pending_items.push_back(seg_item(0, 0, ONE, ONE, 0));
		drain();

		write_tiles(NT);
		// a box inverted in x and a box inverted in both axes at the range limits
		pending_items.push_back(box_item(5, -2 * ONE - 1, -4 * ONE, -3 * ONE, -3 * ONE - 1));
		pending_items.push_back(box_item(63, 524287, 524287, -524288, -524288));
		pending_items.push_back(seg_item(0, 0, 0, 0, 0));
		pending_items.push_back(seg_item(-ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2, 0));
		pending_items.push_back(seg_item(-ONE, -ONE / 2, -ONE, -ONE / 2, 0));
		pending_items.push_back(seg_item(-4 * ONE, 3 * ONE, 4 * ONE, 3 * ONE, 0));
		pending_items.push_back(seg_item(3 * ONE / 2, -4 * ONE, 3 * ONE / 2, 4 * ONE, 0));
		pending_items.push_back(seg_item(-4 * ONE, -4 * ONE, 4 * ONE, 4 * ONE, 0));
		pending_items.push_back(seg_item(4 * ONE, 4 * ONE, -4 * ONE, -4 * ONE, 1));
		pending_items.push_back(seg_item(-524288, -524288, 524287, 524287, 524287));
		pending_items.push_back(seg_item(524287, -524288, -524288, 524287, 0));
		pending_items.push_back(seg_item(6 * ONE, 6 * ONE, 7 * ONE, 7 * ONE, 3));
		pending_items.push_back(seg_item(6 * ONE, 6 * ONE, 7 * ONE, 7 * ONE, 8 * ONE));
		pending_items.push_back(seg_item(4 * ONE + 1, 0, 5 * ONE, 0, 2));
		pending_items.push_back(seg_item(4 * ONE + 1, 0, 5 * ONE, 0, 3));
		pending_items.push_back(seg_item(-ONE / 3, ONE / 4, ONE / 2, -ONE / 5, ONE / 2));
		drain();

		rand_phase(127, 120);
		rand_phase(1, 60);
		rand_phase($urandom_range(2, 63), 100);
		rand_phase(NT, 90);

		$display("Sent %0d loads and %0d lines; %0d tile hits among %0d results checked.",
			n_loads, n_lines, n_hits, n_results);
		$display("Tile counts covered 0, 1, 64, saturating 127 and a random middle value.");
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", bin_expect.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
